// ----- rtl/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained hash table package
// Sizes, mix constants, item codes and memory entry types of the hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int BUCKET_BITS = 10;
  localparam int POOL_DEPTH  = 1024;
  localparam int HEAD_DEPTH  = 1 << BUCKET_BITS;
  localparam int NODE_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W       = NODE_W + 1;
  localparam int CFG_W       = 4;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int MATCH_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 56;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MIX_SEED  = 64'h8445d61a4e774912;
  localparam logic [63:0] MIX_H0    = MIX_SEED ^ (MIX_MUL << 3);
  localparam int          MIX_SHIFT = 47;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] idx;
  } link_t;

  typedef struct packed {
    link_t              link;
    logic [VALUE_W-1:0] payload;
    logic [KEY_W-1:0]   key;
  } node_t;

endpackage

// ----- rtl/chained_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// Chained hash table engine
// Hash-join build and probe table: insert pushes a node onto its bucket
// chain, lookup walks the chain, clear empties every bucket.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transaction per request; tuser carries the kind
//   (insert, lookup, clear), tdata the key and value. Master channel m_*: one
//   transaction per request with the status in tuser and value, match count
//   and node index in tdata. cfg_we/cfg_data set bucket_bits; the user must
//   write them only while idle, as the block does not enforce it. A new
//   request is taken only once the last result is in the output register.
//   A refused insert or an unknown kind skips the key mix. The time to a
//   result is set by the key mix, four 64-bit multiplies each done as three
//   32x32 partial products on one shared multiplier, and by the chain walk,
//   one node per cycle through the node memory read port. A clear sweeps the
//   1024 bucket heads one per cycle.
//   After reset the same sweep runs before s_tready rises.
//   A result waits in the output register while m_tready is low; the next
//   request is still taken and runs until its own result is due.
// ----------------------------------------------------------------------------
module chained_hash_table_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cht_pkg::S_DATA_W-1:0]  s_tdata,   // key[63:0], value[95:64]
  input  logic [cht_pkg::KIND_W-1:0]    s_tuser,   // kind[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cht_pkg::M_DATA_W-1:0]  m_tdata,   // found_value[31:0],
                                                   // match_count[42:32],
                                                   // node_index[52:43], zero
  output logic [cht_pkg::STATUS_W-1:0]  m_tuser,   // status[2:0]
  input  logic                          cfg_we,
  input  logic [cht_pkg::CFG_W-1:0]     cfg_data
);
  import cht_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HREAD = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]              state, state_next;
  logic [CFG_W-1:0]        bucket_bits;
  logic [CNT_W-1:0]        node_count, node_count_next;
  logic [BUCKET_BITS-1:0]  sweep, sweep_next;

  logic [KIND_W-1:0]       kind_r;
  logic [KEY_W-1:0]        key_r;
  logic [VALUE_W-1:0]      val_r;
  logic [63:0]             mul_a, mul_a_next;
  logic [63:0]             acc, acc_next;
  logic [1:0]              mul_idx, mul_idx_next;
  logic [1:0]              part, part_next;
  logic [BUCKET_BITS-1:0]  bucket, bucket_next;
  logic [NODE_W-1:0]       cur, cur_next;

  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic [VALUE_W-1:0]      res_fval, res_fval_next;
  logic [MATCH_W-1:0]      res_count, res_count_next;
  logic [INDEX_W-1:0]      res_idx, res_idx_next;

  logic                    out_free;
  logic                    s_fire;

  logic [31:0]             mul_x, mul_y;
  logic [63:0]             prod, sum_hi, post_xs;
  logic [CFG_W-1:0]        bits_sat;
  logic [BUCKET_BITS-1:0]  bucket_mask;

  link_t                   head_mem [HEAD_DEPTH];
  node_t                   node_mem [POOL_DEPTH];
  link_t                   head_q;
  node_t                   node_q;

  logic                    head_we, head_re;
  logic [BUCKET_BITS-1:0]  head_waddr, head_raddr;
  link_t                   head_wdata;
  logic                    node_we, node_re;
  logic [NODE_W-1:0]       node_waddr, node_raddr;
  node_t                   node_wdata;

  logic                    walk_match;
  logic [MATCH_W-1:0]      walk_count;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    priority if (bucket_bits == '0) begin
      bits_sat = CFG_W'(1);
    end else if (bucket_bits > CFG_W'(BUCKET_BITS)) begin
      bits_sat = CFG_W'(BUCKET_BITS);
    end else begin
      bits_sat = bucket_bits;
    end
    for (int i = 0; i < BUCKET_BITS; i++) begin
      bucket_mask[i] = (CFG_W'(i) < bits_sat);
    end
  end

  always_comb begin
    unique case (part)
      2'd1:    mul_x = mul_a[63:32];
      default: mul_x = mul_a[31:0];
    endcase
    mul_y   = (part == 2'd2) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    prod    = mul_x * mul_y;
    sum_hi  = acc + {prod[31:0], 32'b0};
    post_xs = sum_hi ^ (sum_hi >> MIX_SHIFT);
  end

  assign walk_match = (node_q.key == key_r);
  assign walk_count = res_count + MATCH_W'(walk_match);

  always_comb begin
    state_next      = state;
    node_count_next = node_count;
    sweep_next      = sweep;
    mul_a_next      = mul_a;
    acc_next        = acc;
    mul_idx_next    = mul_idx;
    part_next       = part;
    bucket_next     = bucket;
    cur_next        = cur;
    res_status_next = res_status;
    res_fval_next   = res_fval;
    res_count_next  = res_count;
    res_idx_next    = res_idx;
    head_we         = 1'b0;
    head_waddr      = sweep;
    head_wdata      = '0;
    head_re         = 1'b0;
    head_raddr      = bucket;
    node_we         = 1'b0;
    node_waddr      = node_count[NODE_W-1:0];
    node_wdata      = node_t'{link: head_q, payload: val_r, key: key_r};
    node_re         = 1'b0;
    node_raddr      = head_q.idx;

    unique case (state)
      S_INIT, S_CLEAR: begin
        head_we    = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == '1) begin
          state_next = (state == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          res_status_next = ST_MISSING;
          res_fval_next   = '0;
          res_count_next  = '0;
          res_idx_next    = '0;
          mul_a_next      = s_tdata[KEY_W-1:0];
          mul_idx_next    = '0;
          part_next       = '0;
          unique case (s_tuser)
            KIND_INSERT: begin
              if (node_count == CNT_W'(POOL_DEPTH)) begin
                res_status_next = ST_FULL;
                state_next      = S_RESP;
              end else begin
                state_next = S_HASH;
              end
            end
            KIND_LOOKUP: begin
              state_next = S_HASH;
            end
            KIND_CLEAR: begin
              res_status_next = ST_CLEARED;
              node_count_next = '0;
              sweep_next      = '0;
              state_next      = S_CLEAR;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_HASH: begin
        unique case (part)
          2'd0: begin
            acc_next  = prod;
            part_next = 2'd1;
          end
          2'd1: begin
            acc_next  = sum_hi;
            part_next = 2'd2;
          end
          default: begin
            part_next    = 2'd0;
            mul_idx_next = mul_idx + 1'b1;
            unique case (mul_idx)
              2'd1:    mul_a_next = MIX_H0 ^ sum_hi;
              2'd3: begin
                bucket_next = post_xs[BUCKET_BITS-1:0] & bucket_mask;
                state_next  = S_HREAD;
              end
              default: mul_a_next = post_xs;
            endcase
          end
        endcase
      end
      S_HREAD: begin
        head_re    = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        if (kind_r == KIND_INSERT) begin
          node_we         = 1'b1;
          head_we         = 1'b1;
          head_waddr      = bucket;
          head_wdata      = link_t'{valid: 1'b1, idx: node_count[NODE_W-1:0]};
          node_count_next = node_count + 1'b1;
          res_status_next = ST_INSERTED;
          res_idx_next    = INDEX_W'(node_count[NODE_W-1:0]);
          state_next      = S_RESP;
        end else if (head_q.valid) begin
          node_re    = 1'b1;
          cur_next   = head_q.idx;
          state_next = S_WALK;
        end else begin
          state_next = S_RESP;
        end
      end
      S_WALK: begin
        if (walk_match && (res_count == '0)) begin
          res_fval_next = node_q.payload;
          res_idx_next  = INDEX_W'(cur);
        end
        res_count_next  = walk_count;
        res_status_next = (walk_count != '0) ? ST_FOUND : ST_MISSING;
        if (node_q.link.valid) begin
          node_re    = 1'b1;
          node_raddr = node_q.link.idx;
          cur_next   = node_q.link.idx;
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_q <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      node_count  <= '0;
      bucket_bits <= CFG_W'(BUCKET_BITS);
      m_tvalid    <= 1'b0;
    end else begin
      state      <= state_next;
      sweep      <= sweep_next;
      node_count <= node_count_next;
      if (cfg_we) begin
        bucket_bits <= cfg_data;
      end
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      kind_r <= s_tuser;
      key_r  <= s_tdata[KEY_W-1:0];
      val_r  <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
    end
    mul_a      <= mul_a_next;
    acc        <= acc_next;
    mul_idx    <= mul_idx_next;
    part       <= part_next;
    bucket     <= bucket_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_fval   <= res_fval_next;
    res_count  <= res_count_next;
    res_idx    <= res_idx_next;
    if (state == S_RESP && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {(M_DATA_W - VALUE_W - MATCH_W - INDEX_W)'(0),
                  res_idx, res_count, res_fval};
    end
  end

endmodule
